[hw/rtl/mrhd_pkg.sv]
// ----------------------------------------------------------------------------
// mrhd_pkg
// Shared types, codes and elaboration helpers for the record header deframer.
// ----------------------------------------------------------------------------
package mrhd_pkg;

  // Kind of a result transaction
  typedef enum logic [1:0] {
    KIND_FIELD   = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_VERDICT = 2'd3
  } mrhd_kind_t;

  // Header field identifiers
  typedef enum logic [2:0] {
    FID_GENERATION = 3'd0,
    FID_STREAM     = 3'd1,
    FID_FIRST_FRM  = 3'd2,
    FID_TIMESTAMP  = 3'd3,
    FID_FREQUENCY  = 3'd4,
    FID_FLAGS      = 3'd5,
    FID_PAY_LEN    = 3'd6,
    FID_NONE       = 3'd7
  } mrhd_fid_t;

  // Verdict / error codes
  typedef enum logic [3:0] {
    ERR_OK      = 4'd0,
    ERR_SHORT   = 4'd1,
    ERR_MAGIC   = 4'd2,
    ERR_VERSION = 4'd3,
    ERR_HEADER  = 4'd4,
    ERR_LENGTH  = 4'd5,
    ERR_PAYLOAD = 4'd6,
    ERR_FLAGS   = 4'd7,
    ERR_ZERO    = 4'd8
  } mrhd_err_t;

  localparam int          CNT_W      = 18;
  localparam logic [17:0] CNT_MAX    = 18'h3FFFF;
  localparam logic [17:0] HDR_BYTES  = 18'd116;
  localparam logic [31:0] MAGIC_WORD = 32'h3154414d;
  localparam logic [31:0] FLAG_MASK  = 32'h0000000f;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified input byte: an optional data transaction and an optional verdict
  typedef struct packed {
    logic        has_item;
    mrhd_kind_t  kind;
    mrhd_fid_t   field_id;
    logic [63:0] value;
    logic [15:0] index;
    logic        has_verdict;
    mrhd_err_t   verdict;
  } mrhd_entry_t;

  // Number of trailing zero bits of a positive constant
  function automatic int trail_zeros(input int v);
    int n;
    int t;
    n = 0;
    t = v;
    for (int i = 0; i < 13; i++) begin
      if (t[0] == 1'b0) begin
        n = n + 1;
        t = t >> 1;
      end
    end
    return n;
  endfunction

  // Multiplicative inverse of an odd value modulo 2^18 (Newton iteration)
  function automatic logic [17:0] inv_mod18(input logic [17:0] odd);
    logic [35:0] p;
    logic [35:0] q;
    logic [17:0] x;
    x = odd;
    for (int i = 0; i < 4; i++) begin
      p = 36'(x) * 36'(odd);
      q = 36'(x) * 36'(18'd2 - p[17:0]);
      x = q[17:0];
    end
    return x;
  endfunction

endpackage

[hw/rtl/mrhd_front.sv]
// ----------------------------------------------------------------------------
// mrhd_front
// Counts record bytes, assembles header words, runs the header checks and
// classifies each byte into a queue entry.
// ----------------------------------------------------------------------------
module mrhd_front #(
  parameter int MAX_PAYLOAD   = 65536,
  parameter int FRAME_BYTES   = 4,
  parameter int VERSION_MAJOR = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 frame_end,
  output logic                 entry_push,
  output mrhd_pkg::mrhd_entry_t entry
);

  // Divisibility by FRAME_BYTES: low zero bits, then exact-division test
  // against the odd factor through its modular inverse.
  localparam int          FrameTz   = mrhd_pkg::trail_zeros(FRAME_BYTES);
  localparam int          FrameOdd  = FRAME_BYTES >> FrameTz;
  localparam logic [17:0] FrameInv  = mrhd_pkg::inv_mod18(18'(FrameOdd));
  localparam logic [17:0] FrameLim  = 18'((2**18 - 1) / FrameOdd);
  localparam logic [17:0] FrameMask = 18'((1 << FrameTz) - 1);

  logic [17:0]          cnt_r, cnt_nxt;
  logic [63:0]          wa_r, wa_nxt;
  logic [31:0]          total_r, total_nxt;
  mrhd_pkg::mrhd_err_t  ferr_r, ferr_nxt;

  logic [31:0] w32;
  logic [15:0] w16;
  logic [17:0] pay_low;
  logic [17:0] pay_shr;
  logic [35:0] pay_prod;
  logic        pay_div_ok;
  logic [32:0] pay_sum;

  mrhd_pkg::mrhd_err_t err;
  mrhd_pkg::mrhd_err_t verdict;
  mrhd_pkg::mrhd_entry_t e;

  // last four / two bytes including the current one
  assign w32      = {data_byte, wa_r[63:40]};
  assign w16      = {data_byte, wa_r[63:56]};
  assign pay_low  = w32[17:0];
  assign pay_shr  = pay_low >> FrameTz;
  assign pay_prod = 36'(pay_shr) * 36'(FrameInv);
  assign pay_div_ok = ((pay_low & FrameMask) == 18'd0) && (pay_prod[17:0] <= FrameLim);
  assign pay_sum  = 33'(w32) + 33'(mrhd_pkg::HDR_BYTES);

  always_comb begin
    wa_nxt    = {data_byte, wa_r[63:8]};
    cnt_nxt   = (cnt_r < mrhd_pkg::CNT_MAX) ? cnt_r + 18'd1 : cnt_r;
    total_nxt = total_r;
    ferr_nxt  = ferr_r;
    err       = mrhd_pkg::ERR_OK;
    verdict   = mrhd_pkg::ERR_OK;

    e             = '0;
    e.kind        = mrhd_pkg::KIND_FIELD;
    e.field_id    = mrhd_pkg::FID_NONE;
    e.verdict     = mrhd_pkg::ERR_OK;

    if (ferr_r == mrhd_pkg::ERR_OK) begin
      case (cnt_r)
        18'd3: begin
          if (w32 != mrhd_pkg::MAGIC_WORD) err = mrhd_pkg::ERR_MAGIC;
        end
        18'd5: begin
          if (w16 != 16'(VERSION_MAJOR)) err = mrhd_pkg::ERR_VERSION;
        end
        18'd7: begin
          if (w16 != 16'd0) err = mrhd_pkg::ERR_VERSION;
        end
        18'd9: begin
          if (w16 != 16'(mrhd_pkg::HDR_BYTES)) err = mrhd_pkg::ERR_HEADER;
        end
        18'd11: begin
          // reserved word must be zero
          if (w16 != 16'd0) err = mrhd_pkg::ERR_HEADER;
        end
        18'd15: begin
          total_nxt = w32;
        end
        18'd19: begin
          e.value = 64'(w32);
          if ((w32 & ~mrhd_pkg::FLAG_MASK) != 32'd0) err = mrhd_pkg::ERR_FLAGS;
          else begin
            e.has_item = 1'b1;
            e.field_id = mrhd_pkg::FID_FLAGS;
          end
        end
        18'd27, 18'd35, 18'd75: begin
          e.value = wa_nxt;
          if (wa_nxt == 64'd0) err = mrhd_pkg::ERR_ZERO;
          else begin
            e.has_item = 1'b1;
            e.field_id = (cnt_r == 18'd27) ? mrhd_pkg::FID_GENERATION :
                         (cnt_r == 18'd35) ? mrhd_pkg::FID_STREAM :
                                             mrhd_pkg::FID_FREQUENCY;
          end
        end
        18'd59, 18'd67: begin
          e.value    = wa_nxt;
          e.has_item = 1'b1;
          e.field_id = (cnt_r == 18'd59) ? mrhd_pkg::FID_FIRST_FRM :
                                           mrhd_pkg::FID_TIMESTAMP;
        end
        18'd79: begin
          e.value = 64'(w32);
          if (w32 == 32'd0 || w32 > 32'(MAX_PAYLOAD) || !pay_div_ok)
            err = mrhd_pkg::ERR_PAYLOAD;
          else if (pay_sum != 33'(total_r))
            err = mrhd_pkg::ERR_LENGTH;
          else begin
            e.has_item = 1'b1;
            e.field_id = mrhd_pkg::FID_PAY_LEN;
          end
        end
        default: begin
          if (cnt_r >= 18'd36 && cnt_r < 18'd52) begin
            e.has_item = 1'b1;
            e.kind     = mrhd_pkg::KIND_DESC;
            e.value    = 64'(data_byte);
            e.index    = 16'(cnt_r - 18'd36);
          end else if (cnt_r >= 18'd80 && cnt_r < mrhd_pkg::HDR_BYTES) begin
            e.has_item = 1'b1;
            e.kind     = mrhd_pkg::KIND_DESC;
            e.value    = 64'(data_byte);
            e.index    = 16'(cnt_r - 18'd64);
          end else if (cnt_r >= mrhd_pkg::HDR_BYTES) begin
            if (32'(cnt_r) >= total_r) err = mrhd_pkg::ERR_LENGTH;
            else begin
              e.has_item = 1'b1;
              e.kind     = mrhd_pkg::KIND_PAYLOAD;
              e.value    = 64'(data_byte);
              e.index    = cnt_r[15:0] - 16'(mrhd_pkg::HDR_BYTES);
            end
          end
        end
      endcase

      if (err != mrhd_pkg::ERR_OK) begin
        ferr_nxt   = err;
        e.has_item = 1'b0;
      end
      if (e.has_item && e.kind != mrhd_pkg::KIND_FIELD) e.field_id = mrhd_pkg::FID_GENERATION;
    end

    if (!e.has_item) begin
      e.field_id = mrhd_pkg::FID_GENERATION;
      e.value    = '0;
    end

    if (frame_end) begin
      verdict = ferr_nxt;
      if (verdict == mrhd_pkg::ERR_OK) begin
        if (cnt_nxt < mrhd_pkg::HDR_BYTES) verdict = mrhd_pkg::ERR_SHORT;
        else if (32'(cnt_nxt) != total_nxt) verdict = mrhd_pkg::ERR_LENGTH;
      end
      e.has_verdict = 1'b1;
      e.verdict     = verdict;
      // record closed: back to reset state
      cnt_nxt   = '0;
      wa_nxt    = '0;
      total_nxt = '0;
      ferr_nxt  = mrhd_pkg::ERR_OK;
    end
  end

  assign entry      = e;
  assign entry_push = accept && (e.has_item || e.has_verdict);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      wa_r    <= '0;
      total_r <= '0;
      ferr_r  <= mrhd_pkg::ERR_OK;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      wa_r    <= wa_nxt;
      total_r <= total_nxt;
      ferr_r  <= ferr_nxt;
    end
  end

endmodule

[hw/rtl/mrhd_queue.sv]
// ----------------------------------------------------------------------------
// mrhd_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module mrhd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mrhd_pkg::mrhd_entry_t wr_data,
  output logic                  full,
  input  logic                  pop,
  output mrhd_pkg::mrhd_entry_t rd_data,
  output logic                  empty
);

  mrhd_pkg::mrhd_entry_t slot_r [mrhd_pkg::QUEUE_DEPTH];

  logic [mrhd_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [mrhd_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [mrhd_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign full    = (cnt_r == (mrhd_pkg::QPTR_W + 1)'(mrhd_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wptr_r] <= wr_data;
  end

endmodule

[hw/rtl/mrhd_back.sv]
// ----------------------------------------------------------------------------
// mrhd_back
// Drains queue entries into the result register, one transaction per cycle
// while out_pop is high; an entry with data and a verdict yields the data first.
// ----------------------------------------------------------------------------
module mrhd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  mrhd_pkg::mrhd_entry_t q_head,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [1:0]            out_item_kind,
  output logic [2:0]            out_field_id,
  output logic [63:0]           out_field_value,
  output logic [15:0]           out_byte_index,
  output logic [3:0]            out_verdict,
  output logic                  out_is_last
);

  logic                valid_r, valid_nxt;
  logic                pend_r, pend_nxt;
  mrhd_pkg::mrhd_err_t pend_verdict_r, pend_verdict_nxt;
  logic                load;
  logic                take_item;

  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  fid_r, fid_nxt;
  logic [63:0] value_r, value_nxt;
  logic [15:0] index_r, index_nxt;
  logic [3:0]  verdict_r, verdict_nxt;
  logic        last_r, last_nxt;

  assign load = !valid_r || out_pop;

  always_comb begin
    valid_nxt        = valid_r;
    pend_nxt         = pend_r;
    pend_verdict_nxt = pend_verdict_r;
    q_pop            = 1'b0;
    take_item        = 1'b0;
    kind_nxt         = kind_r;
    fid_nxt          = fid_r;
    value_nxt        = value_r;
    index_nxt        = index_r;
    verdict_nxt      = verdict_r;
    last_nxt         = last_r;

    if (load) begin
      valid_nxt = 1'b0;
      if (pend_r) begin
        valid_nxt   = 1'b1;
        pend_nxt    = 1'b0;
        kind_nxt    = mrhd_pkg::KIND_VERDICT;
        fid_nxt     = '0;
        value_nxt   = '0;
        index_nxt   = '0;
        verdict_nxt = pend_verdict_r;
        last_nxt    = 1'b1;
      end else if (!q_empty) begin
        valid_nxt = 1'b1;
        q_pop     = 1'b1;
        take_item = q_head.has_item;
        if (take_item) begin
          pend_nxt         = q_head.has_verdict;
          pend_verdict_nxt = q_head.verdict;
          kind_nxt         = q_head.kind;
          fid_nxt          = q_head.field_id;
          value_nxt        = q_head.value;
          index_nxt        = q_head.index;
          verdict_nxt      = '0;
          last_nxt         = 1'b0;
        end else begin
          kind_nxt    = mrhd_pkg::KIND_VERDICT;
          fid_nxt     = '0;
          value_nxt   = '0;
          index_nxt   = '0;
          verdict_nxt = q_head.verdict;
          last_nxt    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= 1'b0;
      pend_r         <= 1'b0;
      pend_verdict_r <= mrhd_pkg::ERR_OK;
    end else begin
      valid_r        <= valid_nxt;
      pend_r         <= pend_nxt;
      pend_verdict_r <= pend_verdict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    fid_r     <= fid_nxt;
    value_r   <= value_nxt;
    index_r   <= index_nxt;
    verdict_r <= verdict_nxt;
    last_r    <= last_nxt;
  end

  assign out_empty       = !valid_r;
  assign out_item_kind   = kind_r;
  assign out_field_id    = fid_r;
  assign out_field_value = value_r;
  assign out_byte_index  = index_r;
  assign out_verdict     = verdict_r;
  assign out_is_last     = last_r;

endmodule

[hw/rtl/media_record_header_deframer_unit.sv]
// ----------------------------------------------------------------------------
// media_record_header_deframer_unit
// Record header deframer: checks a 116-byte little-endian header and forwards
// header fields, descriptor bytes, payload bytes and a closing verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive in_data_byte / in_frame_end and raise
//   in_push; the transaction is taken when in_full is low. in_frame_end
//   marks the last byte of a record.
//   Result side is a queue too: while out_empty is low the oldest result is
//   on the out_ ports; pulsing out_pop takes it.
//   Each byte yields zero or one data result; the final byte also yields a
//   verdict result (out_is_last = 1). Downstream keeps a record only when
//   the verdict is ok. After the first error in a record only its verdict
//   is produced.
// Timing:
//   One byte accepted per cycle while in_full is low. A byte is classified
//   and written into the entry queue when it is accepted; its result is
//   loaded into the result register once that register is free.
//   A byte that carries both a data result and a verdict occupies the result
//   register with each in turn, data result first; the four-entry queue absorbs that.
//   When the receiver stalls, the queue fills and in_full rises.
// Reset: rst_n (synchronous, low) empties the queue and result register and
//   restarts record parsing at byte zero.
// ----------------------------------------------------------------------------
module media_record_header_deframer_unit #(
  parameter int MAX_PAYLOAD   = 65536,
  parameter int FRAME_BYTES   = 4,
  parameter int VERSION_MAJOR = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_item_kind,
  output logic [2:0]  out_field_id,
  output logic [63:0] out_field_value,
  output logic [15:0] out_byte_index,
  output logic [3:0]  out_verdict,
  output logic        out_is_last
);

  logic                  accept;
  logic                  entry_push;
  mrhd_pkg::mrhd_entry_t entry;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  mrhd_pkg::mrhd_entry_t q_head;

  // A byte transaction completes whenever the entry queue has room.
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Front: byte counter, word assembly, header checks, classification.
  mrhd_front #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .FRAME_BYTES   (FRAME_BYTES),
    .VERSION_MAJOR (VERSION_MAJOR)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .frame_end  (in_frame_end),
    .entry_push (entry_push),
    .entry      (entry)
  );

  // Decoupling queue: front and back stall independently.
  mrhd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (entry_push),
    .wr_data (entry),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // Back: splits entries into result transactions in the output register.
  mrhd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_item_kind   (out_item_kind),
    .out_field_id    (out_field_id),
    .out_field_value (out_field_value),
    .out_byte_index  (out_byte_index),
    .out_verdict     (out_verdict),
    .out_is_last     (out_is_last)
  );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record header deframer. A short table of
// hand-built records opens the run; then whole records are generated, valid
// ones with random content and ones broken at each header check. Every
// accepted byte goes through a behavioral copy of the deframer, and every
// popped result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import mrhd_pkg::*;

  // Block configuration, kept in step with the instance below
  localparam int MAX_PAYLOAD   = 65536;
  localparam int FRAME_BYTES   = 4;
  localparam int VERSION_MAJOR = 1;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_BYTES  = 450;  // random part keeps going until this many bytes
  localparam int HOLD_CYCLES   = 300;  // one long receiver hold-off to back up the queue
  localparam int STALL_LIMIT   = 2000; // cycles with no transaction on either side
  localparam int DRAIN_CYCLES  = 8;    // extra wait once every expected result is popped
  localparam int MAX_REPORTS   = 40;
  localparam int NUM_DIRECTED  = 23;

  // Header byte offsets (little endian)
  localparam int OFS_MAGIC    = 0;
  localparam int OFS_MAJOR    = 4;
  localparam int OFS_MINOR    = 6;
  localparam int OFS_HSIZE    = 8;
  localparam int OFS_RSVD     = 10;
  localparam int OFS_TOTAL    = 12;
  localparam int OFS_FLAGS    = 16;
  localparam int OFS_GEN      = 20;
  localparam int OFS_STREAM   = 28;
  localparam int OFS_DESC_LO  = 36;
  localparam int OFS_FIRST    = 52;
  localparam int OFS_TSTAMP   = 60;
  localparam int OFS_FREQ     = 68;
  localparam int OFS_PAYLEN   = 76;
  localparam int OFS_DESC_HI  = 80;

  // field_id reads zero on anything that is not a header field
  localparam logic [2:0] NO_FIELD = 3'd0;

  // Ways to build a record
  typedef enum int {
    REC_GOOD,
    REC_BAD_MAGIC,
    REC_BAD_MAJOR,
    REC_BAD_MINOR,
    REC_BAD_HSIZE,
    REC_BAD_RESERVED,
    REC_BAD_FLAGS,
    REC_ZERO_GEN,
    REC_ZERO_STREAM,
    REC_ZERO_FREQ,
    REC_PAY_ZERO,
    REC_PAY_BIG,
    REC_PAY_UNALIGNED,
    REC_TOTAL_MISMATCH,
    REC_EXCESS,
    REC_CUT_HEADER,
    REC_CUT_PAYLOAD,
    REC_NOISE,
    REC_SATURATE
  } rec_mode_t;

  typedef struct {
    mrhd_kind_t  kind;
    logic [2:0]  fid;
    logic [63:0] value;
    logic [15:0] index;
    mrhd_err_t   verdict;
    logic        last;
  } deframe_item_t;

  typedef struct {
    logic [7:0] data;
    logic       fe;
    logic       typed;   // verdict typed in below instead of predicted
    mrhd_err_t  verdict;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_item_kind;
  logic [2:0]  out_field_id;
  logic [63:0] out_field_value;
  logic [15:0] out_byte_index;
  logic [3:0]  out_verdict;
  logic        out_is_last;

  // Predictor state: mirrors the deframer's record parsing
  logic [17:0] rec_count;
  logic [63:0] word_sr;
  logic [31:0] rec_total;
  logic [31:0] rec_payload;
  mrhd_err_t   rec_err;

  deframe_item_t step_items[$];     // results caused by the byte just accepted
  deframe_item_t pending_items[$];  // predicted results not yet popped
  deframe_item_t want;
  logic [7:0]    rec_hdr [116];

  // Run control and bookkeeping
  logic        idle_on;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          bytes_sent = 0;
  int          records_sent = 0;
  int          results_checked = 0;
  logic [15:0] verdict_seen = '0;

  directed_row_t dir_rows [NUM_DIRECTED];

  media_record_header_deframer_unit #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .FRAME_BYTES  (FRAME_BYTES),
    .VERSION_MAJOR(VERSION_MAJOR)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_byte   (in_data_byte),
    .in_frame_end   (in_frame_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_item_kind  (out_item_kind),
    .out_field_id   (out_field_id),
    .out_field_value(out_field_value),
    .out_byte_index (out_byte_index),
    .out_verdict    (out_verdict),
    .out_is_last    (out_is_last)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic deframe_item_t make_item(mrhd_kind_t kind, logic [2:0] fid,
                                              logic [63:0] value, logic [15:0] index,
                                              mrhd_err_t verdict, logic last);
    deframe_item_t it;
    it.kind    = kind;
    it.fid     = fid;
    it.value   = value;
    it.index   = index;
    it.verdict = verdict;
    it.last    = last;
    return it;
  endfunction

  function automatic void clear_record_state();
    rec_count   = '0;
    word_sr     = '0;
    rec_total   = '0;
    rec_payload = '0;
    rec_err     = ERR_OK;
  endfunction

  // Advance the record state by one byte and collect the results it causes
  // in step_items. word_sr shifts in from the top, so the last N bytes of a
  // little-endian word sit in its top N bytes.
  function automatic void deframe_predict(input logic [7:0] b, input logic fe);
    logic [17:0] pos;
    logic [63:0] v;
    mrhd_err_t   err;
    mrhd_err_t   vd;
    int          fid;
    step_items.delete();
    pos     = rec_count;
    word_sr = {b, word_sr[63:8]};
    if (rec_count != CNT_MAX) rec_count = rec_count + 18'd1;

    if (rec_err == ERR_OK) begin
      fid = -1;
      v   = '0;
      err = ERR_OK;
      case (pos)
        18'd3:  if (word_sr[63:32] != MAGIC_WORD) err = ERR_MAGIC;
        18'd5:  if (word_sr[63:48] != 16'(VERSION_MAJOR)) err = ERR_VERSION;
        18'd7:  if (word_sr[63:48] != 16'd0) err = ERR_VERSION;
        18'd9:  if (word_sr[63:48] != 16'(HDR_BYTES)) err = ERR_HEADER;
        18'd11: if (word_sr[63:48] != 16'd0) err = ERR_HEADER;
        18'd15: rec_total = word_sr[63:32];
        18'd19: begin
          v = {32'd0, word_sr[63:32]};
          if ((word_sr[63:32] & ~FLAG_MASK) != 32'd0) err = ERR_FLAGS;
          else fid = FID_FLAGS;
        end
        18'd27, 18'd35, 18'd75: begin
          v = word_sr;
          if (v == 64'd0) err = ERR_ZERO;
          else if (pos == 18'd27) fid = FID_GENERATION;
          else if (pos == 18'd35) fid = FID_STREAM;
          else fid = FID_FREQUENCY;
        end
        18'd59, 18'd67: begin
          v   = word_sr;
          fid = (pos == 18'd59) ? FID_FIRST_FRM : FID_TIMESTAMP;
        end
        18'd79: begin
          rec_payload = word_sr[63:32];
          v = {32'd0, rec_payload};
          if (rec_payload == 32'd0 || rec_payload > 32'(MAX_PAYLOAD) ||
              rec_payload % 32'(FRAME_BYTES) != 32'd0)
            err = ERR_PAYLOAD;
          else if (64'(rec_payload) + 64'(HDR_BYTES) != 64'(rec_total))
            err = ERR_LENGTH;
          else
            fid = FID_PAY_LEN;
        end
        default: ;
      endcase

      if (err != ERR_OK) begin
        rec_err = err;
      end else if (fid >= 0) begin
        step_items.push_back(make_item(KIND_FIELD, 3'(fid), v, '0, ERR_OK, 1'b0));
      end else if (pos >= 18'd36 && pos < 18'd52) begin
        step_items.push_back(make_item(KIND_DESC, NO_FIELD, {56'd0, b},
                                       16'(pos - 18'd36), ERR_OK, 1'b0));
      end else if (pos >= 18'd80 && pos < HDR_BYTES) begin
        step_items.push_back(make_item(KIND_DESC, NO_FIELD, {56'd0, b},
                                       16'(pos - 18'd64), ERR_OK, 1'b0));
      end else if (pos >= HDR_BYTES) begin
        if (32'(pos) >= rec_total) rec_err = ERR_LENGTH;
        else step_items.push_back(make_item(KIND_PAYLOAD, NO_FIELD, {56'd0, b},
                                            16'(pos - HDR_BYTES), ERR_OK, 1'b0));
      end
    end

    if (fe) begin
      vd = rec_err;
      if (vd == ERR_OK) begin
        if (rec_count < HDR_BYTES) vd = ERR_SHORT;
        else if (32'(rec_count) != rec_total) vd = ERR_LENGTH;
      end
      step_items.push_back(make_item(KIND_VERDICT, NO_FIELD, '0, '0, vd, 1'b1));
      clear_record_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Header words lean toward the extremes now and then
  function automatic logic [63:0] rand_word64();
    logic [63:0] w;
    case ($urandom_range(0, 5))
      0:       w = '1;
      1:       w = 64'd1;
      default: w = {$urandom, $urandom};
    endcase
    if (w == 64'd0) w = 64'd1;
    return w;
  endfunction

  function automatic void put_le(int at, int nbytes, logic [63:0] v);
    for (int i = 0; i < nbytes; i++) rec_hdr[at + i] = v[8*i +: 8];
  endfunction

  // Offer one byte at the falling edge, hold it until taken, then predict.
  task automatic send_byte(input logic [7:0] b, input logic fe,
                           input logic typed, input mrhd_err_t typed_vd);
    int gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (in_full !== 1'b0);
    deframe_predict(b, fe);
    if (typed)
      pending_items.push_back(make_item(KIND_VERDICT, NO_FIELD, '0, '0, typed_vd, 1'b1));
    else
      foreach (step_items[k]) pending_items.push_back(step_items[k]);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Build one record, break it as the mode says, and send it up to its cut
  task automatic send_record(input rec_mode_t mode, input logic big);
    logic [31:0] magic;
    logic [15:0] major;
    logic [15:0] minor;
    logic [15:0] hsize;
    logic [15:0] rsvd;
    logic [31:0] total;
    logic [31:0] flags;
    logic [31:0] pay;
    logic [63:0] gen;
    logic [63:0] strm;
    logic [63:0] freq;
    int          err_pos;
    int          len;
    logic [7:0]  b;

    magic   = MAGIC_WORD;
    major   = 16'(VERSION_MAJOR);
    minor   = 16'd0;
    hsize   = 16'(HDR_BYTES);
    rsvd    = 16'd0;
    flags   = 32'($urandom_range(0, 15));
    gen     = rand_word64();
    strm    = rand_word64();
    freq    = rand_word64();
    err_pos = -1;
    if (big)
      pay = 32'(MAX_PAYLOAD);
    else if ($urandom_range(0, 7) == 0)
      pay = 32'(FRAME_BYTES * $urandom_range(9, 64));
    else
      pay = 32'(FRAME_BYTES * $urandom_range(1, 8));

    case (mode)
      REC_BAD_MAJOR: begin
        major = 16'($urandom);
        if (major == 16'(VERSION_MAJOR)) major = major ^ 16'h8000;
        err_pos = OFS_MAJOR + 1;
      end
      REC_BAD_MINOR: begin
        minor   = 16'($urandom_range(1, 65535));
        err_pos = OFS_MINOR + 1;
      end
      REC_BAD_HSIZE: begin
        hsize = 16'($urandom);
        if (hsize == 16'(HDR_BYTES)) hsize = hsize + 16'd1;
        err_pos = OFS_HSIZE + 1;
      end
      REC_BAD_RESERVED: begin
        rsvd    = 16'($urandom_range(1, 65535));
        err_pos = OFS_RSVD + 1;
      end
      REC_BAD_FLAGS: begin
        flags   = $urandom | (32'd1 << $urandom_range(4, 31));
        err_pos = OFS_FLAGS + 3;
      end
      REC_ZERO_GEN: begin
        gen     = '0;
        err_pos = OFS_GEN + 7;
      end
      REC_ZERO_STREAM: begin
        strm    = '0;
        err_pos = OFS_STREAM + 7;
      end
      REC_ZERO_FREQ: begin
        freq    = '0;
        err_pos = OFS_FREQ + 7;
      end
      REC_PAY_ZERO: begin
        pay     = '0;
        err_pos = OFS_PAYLEN + 3;
      end
      REC_PAY_BIG: begin
        if ($urandom_range(0, 3) == 0) pay = 32'hffff_fffc;
        else pay = 32'(MAX_PAYLOAD + FRAME_BYTES * $urandom_range(1, 16));
        err_pos = OFS_PAYLEN + 3;
      end
      REC_PAY_UNALIGNED: begin
        pay     = 32'(FRAME_BYTES * $urandom_range(1, 8) + $urandom_range(1, FRAME_BYTES - 1));
        err_pos = OFS_PAYLEN + 3;
      end
      REC_TOTAL_MISMATCH: err_pos = OFS_PAYLEN + 3;
      default: ;
    endcase

    total = 32'(HDR_BYTES) + pay;
    if (mode == REC_TOTAL_MISMATCH) begin
      if ($urandom_range(0, 1) == 0) total = total + 32'(FRAME_BYTES * $urandom_range(1, 4));
      else total = total + ($urandom | 32'd1);
    end

    put_le(OFS_MAGIC, 4, {32'd0, magic});
    put_le(OFS_MAJOR, 2, {48'd0, major});
    put_le(OFS_MINOR, 2, {48'd0, minor});
    put_le(OFS_HSIZE, 2, {48'd0, hsize});
    put_le(OFS_RSVD, 2, {48'd0, rsvd});
    put_le(OFS_TOTAL, 4, {32'd0, total});
    put_le(OFS_FLAGS, 4, {32'd0, flags});
    put_le(OFS_GEN, 8, gen);
    put_le(OFS_STREAM, 8, strm);
    put_le(OFS_FIRST, 8, ($urandom_range(0, 5) == 0) ? 64'd0 : rand_word64());
    put_le(OFS_TSTAMP, 8, ($urandom_range(0, 5) == 0) ? 64'd0 : rand_word64());
    put_le(OFS_FREQ, 8, freq);
    put_le(OFS_PAYLEN, 4, {32'd0, pay});
    for (int i = OFS_DESC_LO; i < OFS_FIRST; i++) rec_hdr[i] = rand_byte();
    for (int i = OFS_DESC_HI; i < int'(HDR_BYTES); i++) rec_hdr[i] = rand_byte();

    // Magic is broken in one of its four bytes
    if (mode == REC_BAD_MAGIC) begin
      b = 8'($urandom_range(1, 255));
      rec_hdr[$urandom_range(0, 3)] ^= b;
      err_pos = OFS_MAGIC + 3;
    end
    // Noise: random bytes, sometimes behind a valid magic
    if (mode == REC_NOISE || mode == REC_SATURATE) begin
      for (int i = 4; i < int'(HDR_BYTES); i++) rec_hdr[i] = 8'($urandom_range(0, 255));
      if (mode == REC_SATURATE || $urandom_range(0, 1) == 0)
        for (int i = 0; i < 4; i++) rec_hdr[i] = 8'($urandom_range(0, 255));
      if (mode == REC_SATURATE) rec_hdr[0] = 8'h00;  // guarantees a magic error
    end

    case (mode)
      REC_GOOD:        len = int'(HDR_BYTES) + int'(pay);
      REC_EXCESS:      len = int'(HDR_BYTES) + int'(pay) + $urandom_range(1, 6);
      REC_CUT_HEADER:  len = $urandom_range(1, int'(HDR_BYTES) - 1);
      REC_CUT_PAYLOAD: len = $urandom_range(int'(HDR_BYTES), int'(HDR_BYTES) + int'(pay) - 1);
      REC_NOISE:       len = $urandom_range(1, 40);
      REC_SATURATE:    len = int'(CNT_MAX) + 6;
      default:         len = err_pos + 1 + $urandom_range(0, 12);
    endcase

    for (int i = 0; i < len; i++) begin
      b = (i < int'(HDR_BYTES)) ? rec_hdr[i] : rand_byte();
      send_byte(b, i == len - 1, 1'b0, ERR_OK);
    end
    records_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_items.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("result with nothing expected: kind %0d value %0h", out_item_kind,
                 out_field_value);
      end else begin
        want = pending_items.pop_front();
        check_field("item_kind", 64'(want.kind), 64'(out_item_kind));
        check_field("field_id", 64'(want.fid), 64'(out_field_id));
        check_field("field_value", want.value, out_field_value);
        check_field("byte_index", 64'(want.index), 64'(out_byte_index));
        check_field("verdict", 64'(want.verdict), 64'(out_verdict));
        check_field("is_last", 64'(want.last), 64'(out_is_last));
      end
      results_checked++;
      if (out_is_last === 1'b1) verdict_seen[out_verdict] = 1'b1;
      // Mid-header is a good spot for the long hold-off: plenty of bytes
      // are still to come from the sender
      if (!hold_done && out_item_kind == KIND_DESC && out_byte_index == 16'd10)
        hold_armed = 1'b1;
    end
  end

  // Watchdog: any transaction on either side restarts the count
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_items.size());
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pops at the falling edge, with random gaps and one long
  // hold-off that lets the queue fill and in_full rise
  // --------------------------------------------------------------------------
  initial begin : receiver
    int pop_gap;
    pop_gap = 0;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        pop_gap   = HOLD_CYCLES;
      end else if (pop_gap == 0 && idle_on && $urandom_range(0, 11) == 0) begin
        pop_gap = $urandom_range(1, 16);
      end
      if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rec_mode_t mode;
    int        rec_idx;

    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data_byte = 8'h00;
    in_frame_end = 1'b0;
    idle_on      = 1'b0;
    clear_record_state();

    // Directed records: one-byte records at both byte extremes, a broken
    // magic, a wrong major version and a nonzero minor version. Each record
    // ends just after its error, so its verdict can be typed in directly.
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, ERR_SHORT},
      '{8'hff, 1'b1, 1'b1, ERR_SHORT},
      '{8'h4d, 1'b0, 1'b0, ERR_OK},
      '{8'h41, 1'b0, 1'b0, ERR_OK},
      '{8'h54, 1'b0, 1'b0, ERR_OK},
      '{8'hb1, 1'b0, 1'b0, ERR_OK},
      '{8'hff, 1'b1, 1'b1, ERR_MAGIC},
      '{8'h4d, 1'b0, 1'b0, ERR_OK},
      '{8'h41, 1'b0, 1'b0, ERR_OK},
      '{8'h54, 1'b0, 1'b0, ERR_OK},
      '{8'h31, 1'b0, 1'b0, ERR_OK},
      '{8'h00, 1'b0, 1'b0, ERR_OK},
      '{8'h00, 1'b0, 1'b0, ERR_OK},
      '{8'h7f, 1'b1, 1'b1, ERR_VERSION},
      '{8'h4d, 1'b0, 1'b0, ERR_OK},
      '{8'h41, 1'b0, 1'b0, ERR_OK},
      '{8'h54, 1'b0, 1'b0, ERR_OK},
      '{8'h31, 1'b0, 1'b0, ERR_OK},
      '{8'h01, 1'b0, 1'b0, ERR_OK},
      '{8'h00, 1'b0, 1'b0, ERR_OK},
      '{8'h00, 1'b0, 1'b0, ERR_OK},
      '{8'h80, 1'b0, 1'b0, ERR_OK},
      '{8'h55, 1'b1, 1'b1, ERR_VERSION}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].fe, dir_rows[i].typed, dir_rows[i].verdict);
      if (dir_rows[i].fe) records_sent++;
    end
    bytes_sent = 0;

    // Random records: every construction but REC_SATURATE once in order, then
    // mostly valid records with the broken kinds mixed in
    rec_idx = 0;
    while (rec_idx < int'(REC_SATURATE) || bytes_sent < RANDOM_BYTES) begin
      if (rec_idx < int'(REC_SATURATE))
        mode = rec_mode_t'(rec_idx);
      else if ($urandom_range(0, 99) < 55)
        mode = REC_GOOD;
      else
        mode = rec_mode_t'($urandom_range(1, int'(REC_SATURATE) - 1));
      idle_on = ($urandom_range(0, 3) != 0);
      send_record(mode, 1'b0);
      rec_idx++;
    end

    // Closing stretch without idling: one more valid record
    idle_on = 1'b0;
    send_record(REC_GOOD, 1'b0);

    in_push <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d records (%0d bytes after the directed part), checked %0d results",
             records_sent, bytes_sent, results_checked);
    $display("Verdict codes observed (bit per code): %b, long receiver hold-off done: %0d",
             verdict_seen[8:0], hold_done);
    if (mismatches == 0 && pending_items.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mrhd_pkg.sv
hw/rtl/mrhd_front.sv
hw/rtl/mrhd_queue.sv
hw/rtl/mrhd_back.sv
hw/rtl/media_record_header_deframer_unit.sv
bench/tb_top.sv
